[sv/tqlu_pkg.sv]
`timescale 1ns / 1ps

package tqlu_pkg;

  // Table geometry and value format
  localparam int unsigned PLAYER_SLOTS = 32;
  localparam int unsigned DEALER_SLOTS = 16;
  localparam int unsigned VALUE_WIDTH  = 24;
  localparam int unsigned ROWS         = PLAYER_SLOTS * DEALER_SLOTS * 2;
  localparam int unsigned ROW_W        = $clog2(ROWS);

  // Fixed field widths
  localparam int unsigned REG_W    = 17;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_IX_W = 3;

  // Register reset values (gamma 1.0, alpha 0.02, epsilon 0.1, Sarsa epsilon 0.01)
  localparam logic [REG_W-1:0] DISCOUNT_RST   = 17'd65536;
  localparam logic [REG_W-1:0] LEARN_RATE_RST = 17'd1311;
  localparam logic [REG_W-1:0] EXPLORE_RST    = 17'd6554;
  localparam logic [REG_W-1:0] SARSA_EPS_RST  = 17'd655;

  // Rounding offset: one half in the 16-bit fraction
  localparam int HALF_LSB = 32768;

  typedef logic [ROW_W-1:0]              row_t;
  typedef logic signed [VALUE_WIDTH-1:0] qval_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_UPDATE_MODE = 3'd0,
    CFG_DISCOUNT    = 3'd1,
    CFG_LEARN_RATE  = 3'd2,
    CFG_EXPLORE_EPS = 3'd3,
    CFG_SARSA_EPS   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_QLEARN = 1'b0,
    MODE_SARSA  = 1'b1
  } mode_e;

  typedef enum logic {
    REQ_QUERY  = 1'b0,
    REQ_UPDATE = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEL,
    ST_DIFF,
    ST_MUL,
    ST_WB
  } state_e;

  typedef struct packed {
    logic  en_hit;
    logic  en_stick;
    row_t  row;
    qval_t data;
  } qmem_wr_t;

  typedef struct packed {
    qval_t cur_hit;
    qval_t cur_stick;
    qval_t nxt_hit;
    qval_t nxt_stick;
  } qmem_rd_t;

  typedef struct packed {
    logic act;
    logic explored;
  } pick_t;

  // Row of a state; totals beyond the table clamp to the last slot
  function automatic row_t row_index(logic [4:0] p, logic [3:0] d, logic ace);
    int unsigned ps;
    int unsigned ds;
    int unsigned idx;
    ps  = (32'(p) >= PLAYER_SLOTS) ? PLAYER_SLOTS - 1 : 32'(p);
    ds  = (32'(d) >= DEALER_SLOTS) ? DEALER_SLOTS - 1 : 32'(d);
    idx = (ps * DEALER_SLOTS + ds) * 2 + 32'(ace);
    return row_t'(idx);
  endfunction

endpackage

[sv/tqlu_intf.sv]
`timescale 1ns / 1ps

// Request channel
interface tqlu_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [4:0]        player;
  logic [3:0]        dealer;
  logic              soft_hand;
  logic              action;
  logic [4:0]        next_player;
  logic [3:0]        next_dealer;
  logic              next_ace;
  logic signed [7:0] reward;
  logic [15:0]       rand_explore;
  logic              rand_coin;

  modport source (
    output valid, req_type, player, dealer, soft_hand, action,
           next_player, next_dealer, next_ace, reward, rand_explore, rand_coin,
    input  ready
  );
  modport sink (
    input  valid, req_type, player, dealer, soft_hand, action,
           next_player, next_dealer, next_ace, reward, rand_explore, rand_coin,
    output ready
  );
endinterface

// Result channel
interface tqlu_rsp_if;
  logic               valid;
  logic               ready;
  logic               chosen_action;
  logic signed [23:0] q_value;
  logic               explored;

  modport source (output valid, chosen_action, q_value, explored, input ready);
  modport sink   (input valid, chosen_action, q_value, explored, output ready);
endinterface

// Register write channel
interface tqlu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/tqlu_qmem.sv]
`timescale 1ns / 1ps

module tqlu_qmem (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  tqlu_pkg::row_t     rd_cur_row_i,
  input  tqlu_pkg::row_t     rd_nxt_row_i,
  input  tqlu_pkg::qmem_wr_t wr_i,
  output tqlu_pkg::qmem_rd_t rd_o
);
  import tqlu_pkg::*;

  // One array per action, same row addressing
  qval_t    hit_mem   [ROWS];
  qval_t    stick_mem [ROWS];
  qmem_rd_t rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en_hit) begin
      hit_mem[wr_i.row] <= wr_i.data;
    end
    if (wr_i.en_stick) begin
      stick_mem[wr_i.row] <= wr_i.data;
    end
  end

  // Two registered read ports: current and next state rows
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.cur_hit   <= hit_mem[rd_cur_row_i];
      rd_q.cur_stick <= stick_mem[rd_cur_row_i];
      rd_q.nxt_hit   <= hit_mem[rd_nxt_row_i];
      rd_q.nxt_stick <= stick_mem[rd_nxt_row_i];
    end
  end

  assign rd_o = rd_q;

endmodule

[sv/tabular_q_learning_update.sv]
`timescale 1ns / 1ps
// Query: read of both action values, then epsilon-greedy pick into the result register,
//   which waits while the result register is full. Update: read, gamma multiply, TD difference,
//   alpha multiply, write-back; the result is loaded with the write-back, which also waits for room.
// A new request is taken once the previous item's result has been loaded (for an update, at write-back).
// Reset: registers take their defaults, then a clearing pass zeroes the table, one row
//   a cycle over all ROWS (1024) rows, during which no request is taken; config is always taken.
module tabular_q_learning_update (
  input  logic clk_i,
  input  logic rst_ni,
  tqlu_req_if.sink   req_i,
  tqlu_rsp_if.source rsp_o,
  tqlu_cfg_if.sink   cfg_i
);
  import tqlu_pkg::*;

  localparam int unsigned Q_W  = VALUE_WIDTH;
  localparam int unsigned P1_W = Q_W + REG_W + 1;
  localparam int unsigned G_W  = P1_W - FRAC_W;
  localparam int unsigned D_W  = ((Q_W > OUT_W) ? Q_W : OUT_W) + 4;
  localparam int unsigned P2_W = D_W + REG_W + 1;
  localparam int unsigned R2_W = P2_W - FRAC_W;
  localparam int unsigned S_W  = D_W + 3;

  // Epsilon-greedy choice between two values
  function automatic pick_t pick(logic [REG_W-1:0] eps, logic [15:0] rnd, logic coin,
                                 qval_t hit, qval_t stick);
    pick_t r;
    if ({1'b0, rnd} < eps) begin
      r.explored = 1'b1;
      r.act      = coin;
    end else begin
      r.explored = 1'b0;
      if (hit > stick) begin
        r.act = 1'b0;
      end else if (stick > hit) begin
        r.act = 1'b1;
      end else begin
        r.act = coin;
      end
    end
    return r;
  endfunction

  // Configuration registers
  mode_e            mode_q;
  logic [REG_W-1:0] discount_q;
  logic [REG_W-1:0] learn_rate_q;
  logic [REG_W-1:0] explore_eps_q;
  logic [REG_W-1:0] sarsa_eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_QLEARN;
      discount_q    <= DISCOUNT_RST;
      learn_rate_q  <= LEARN_RATE_RST;
      explore_eps_q <= EXPLORE_RST;
      sarsa_eps_q   <= SARSA_EPS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_UPDATE_MODE: mode_q        <= mode_e'(cfg_i.data[0]);
        CFG_DISCOUNT:    discount_q    <= cfg_i.data;
        CFG_LEARN_RATE:  learn_rate_q  <= cfg_i.data;
        CFG_EXPLORE_EPS: explore_eps_q <= cfg_i.data;
        CFG_SARSA_EPS:   sarsa_eps_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Control state
  state_e state_q, state_d;
  row_t   clr_cnt_q;
  logic   rsp_valid_q;

  logic     accept;
  logic     out_free;
  logic     load_rsp;
  logic     clr_last;
  qmem_wr_t wr;
  qmem_rd_t rd;

  // Request fields held for the item in flight
  req_e              req_type_q;
  logic              act_q;
  row_t              cur_row_q;
  logic signed [7:0] reward_q;
  logic [15:0]       rnd_q;
  logic              coin_q;

  // Datapath registers
  qval_t                  cur_q;
  logic                   chosen_q;
  logic                   explored_q;
  logic signed [P1_W-1:0] prod1_q, prod1_d;
  logic signed [D_W-1:0]  diff_q, diff_d;
  logic signed [P2_W-1:0] prod2_q, prod2_d;

  // Result register
  logic               rsp_act_q, rsp_act_d;
  logic signed [23:0] rsp_val_q, rsp_val_d;
  logic               rsp_exp_q, rsp_exp_d;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign clr_last = (clr_cnt_q == ROW_W'(ROWS - 1));

  tqlu_qmem u_qmem (
    .clk_i        (clk_i),
    .rd_en_i      (accept),
    .rd_cur_row_i (row_index(req_i.player, req_i.dealer, req_i.soft_hand)),
    .rd_nxt_row_i (row_index(req_i.next_player, req_i.next_dealer, req_i.next_ace)),
    .wr_i         (wr),
    .rd_o         (rd)
  );

  // Select stage: policy pick, next-state value, gamma multiply
  pick_t pk_query;
  pick_t pk_sarsa;
  qval_t nq;
  qval_t cur_sel;

  always_comb begin
    pk_query = pick(explore_eps_q, rnd_q, coin_q, rd.cur_hit, rd.cur_stick);
    pk_sarsa = pick(sarsa_eps_q, rnd_q, coin_q, rd.nxt_hit, rd.nxt_stick);
    if (mode_q == MODE_SARSA) begin
      nq = pk_sarsa.act ? rd.nxt_stick : rd.nxt_hit;
    end else begin
      nq = (rd.nxt_hit > rd.nxt_stick) ? rd.nxt_hit : rd.nxt_stick;
    end
    cur_sel = act_q ? rd.cur_stick : rd.cur_hit;
    prod1_d = P1_W'($signed({1'b0, discount_q})) * P1_W'(nq);
  end

  // Difference and multiply stages: target minus current value, then alpha times the difference
  logic signed [P1_W-1:0] p1_rnd;
  logic signed [G_W-1:0]  g;
  logic signed [D_W-1:0]  rew_ext;

  always_comb begin
    p1_rnd  = prod1_q + P1_W'(HALF_LSB);
    g       = $signed(p1_rnd[P1_W-1:FRAC_W]);
    rew_ext = D_W'(reward_q);
    diff_d  = (rew_ext <<< FRAC_W) + D_W'(g) - D_W'(cur_q);
    prod2_d = P2_W'($signed({1'b0, learn_rate_q})) * P2_W'(diff_q);
  end

  // Write-back stage: round, add, saturate
  logic signed [P2_W-1:0] p2_rnd;
  logic signed [R2_W-1:0] r2;
  logic signed [S_W-1:0]  sum;
  qval_t                  new_val;

  always_comb begin
    p2_rnd = prod2_q + P2_W'(HALF_LSB);
    r2     = $signed(p2_rnd[P2_W-1:FRAC_W]);
    sum    = S_W'(r2) + S_W'(cur_q);
    if (sum[S_W-1:Q_W-1] == '0 || sum[S_W-1:Q_W-1] == '1) begin
      new_val = sum[Q_W-1:0];
    end else if (sum[S_W-1]) begin
      new_val = {1'b1, {(Q_W - 1){1'b0}}};
    end else begin
      new_val = {1'b0, {(Q_W - 1){1'b1}}};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_SEL;
      ST_SEL: begin
        if (req_type_q == REQ_UPDATE) begin
          state_d = ST_DIFF;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIFF:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_WB;
      ST_WB:    if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    load_rsp    = 1'b0;
    wr.en_hit   = 1'b0;
    wr.en_stick = 1'b0;
    wr.row      = cur_row_q;
    wr.data     = new_val;
    rsp_act_d   = chosen_q;
    rsp_val_d   = OUT_W'(new_val);
    rsp_exp_d   = explored_q;
    case (state_q)
      ST_CLEAR: begin
        wr.en_hit   = 1'b1;
        wr.en_stick = 1'b1;
        wr.row      = clr_cnt_q;
        wr.data     = '0;
      end
      ST_IDLE: req_i.ready = 1'b1;
      ST_SEL: begin
        if (req_type_q == REQ_QUERY && out_free) begin
          load_rsp  = 1'b1;
          rsp_act_d = pk_query.act;
          rsp_exp_d = pk_query.explored;
          rsp_val_d = OUT_W'(pk_query.act ? rd.cur_stick : rd.cur_hit);
        end
      end
      ST_WB: begin
        if (out_free) begin
          load_rsp    = 1'b1;
          wr.en_hit   = !act_q;
          wr.en_stick = act_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + row_t'(1);
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_e'(req_i.req_type);
      act_q      <= req_i.action;
      cur_row_q  <= row_index(req_i.player, req_i.dealer, req_i.soft_hand);
      reward_q   <= req_i.reward;
      rnd_q      <= req_i.rand_explore;
      coin_q     <= req_i.rand_coin;
    end
  end

  // Advance the update datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      cur_q      <= cur_sel;
      prod1_q    <= prod1_d;
      chosen_q   <= (mode_q == MODE_SARSA) ? pk_sarsa.act : 1'b0;
      explored_q <= (mode_q == MODE_SARSA) ? pk_sarsa.explored : 1'b0;
    end
    if (state_q == ST_DIFF) begin
      diff_q <= diff_d;
    end
    if (state_q == ST_MUL) begin
      prod2_q <= prod2_d;
    end
    if (load_rsp) begin
      rsp_act_q <= rsp_act_d;
      rsp_val_q <= rsp_val_d;
      rsp_exp_q <= rsp_exp_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.chosen_action = rsp_act_q;
  assign rsp_o.q_value       = rsp_val_q;
  assign rsp_o.explored      = rsp_exp_q;

  // A table read never meets a write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(wr.en_hit || wr.en_stick))
    else $error("table read and write collide");

  // Outside the clearing pass only one action entry is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |-> !(wr.en_hit && wr.en_stick))
    else $error("both action entries written by one update");

  // Every write-back is delivered as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wr.en_hit || wr.en_stick) && state_q != ST_CLEAR) |-> load_rsp)
    else $error("write-back without result");

  // The clearing pass ends only after the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> $past(clr_cnt_q) == ROW_W'(ROWS - 1))
    else $error("clearing pass ended early");

  // No write follows the read beat directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !(wr.en_hit || wr.en_stick))
    else $error("write in the select cycle");

endmodule
